// ----- rtl/multi_queue_priority_deque_assert.svh -----
// ---------------------------------------------------------------------------
// multi_queue_priority_deque assertion macros
// Shared property wrappers for the checker of the queue bank.
// ---------------------------------------------------------------------------
`ifndef MULTI_QUEUE_PRIORITY_DEQUE_ASSERT_SVH
`define MULTI_QUEUE_PRIORITY_DEQUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MQPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MQPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mqpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqpd_pkg
// Request, response and chain token types and codes for the queue bank.
// ---------------------------------------------------------------------------
package mqpd_pkg;

    localparam int QIDX_BITS      = 5;
    localparam int TAG_IN_BITS    = 16;
    localparam int LEN_BITS       = 4;
    localparam int CODE_BITS      = 2;
    localparam int QUEUE_MAX_BITS = 6;
    localparam int SLOT_MAX_BITS  = 5;
    localparam int COUNT_MAX_BITS = 6;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    localparam logic [CODE_BITS-1:0] RES_DONE  = 2'd0;
    localparam logic [CODE_BITS-1:0] RES_FULL  = 2'd1;
    localparam logic [CODE_BITS-1:0] RES_EMPTY = 2'd2;

    typedef struct packed {
        logic                   mode;
        logic [QIDX_BITS-1:0]   queue_index;
        logic [TAG_IN_BITS-1:0] item_tag;
        logic                   urgent;
    } req_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]   result_code;
        logic [TAG_IN_BITS-1:0] taken_tag;
        logic                   taken_urgent;
        logic [LEN_BITS-1:0]    new_length;
    } rsp_t;

    typedef struct packed {
        logic                      mode;
        logic [QUEUE_MAX_BITS-1:0] queue;
        logic [TAG_IN_BITS-1:0]    tag;
        logic                      urgent;
        logic [CODE_BITS-1:0]      code;
        logic [SLOT_MAX_BITS-1:0]  slot;
        logic [COUNT_MAX_BITS-1:0] cnt;
    } tok_t;

endpackage
`default_nettype wire

// ----- rtl/multi_queue_priority_deque.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multi_queue_priority_deque
// Bank of bounded queues with head insert for urgent items.
//
// Requests enter on req (valid/ready) and each gives one response on rsp
// (valid/ready). A request is an add (tail, or head when urgent) or a take
// of the head item from the queue chosen by queue_index, which wraps modulo
// NUM_QUEUES. The response carries the status, the taken item and the new
// length of that queue.
// A request walks a chain of NUM_QUEUES cells, one cell per cycle while the
// chain advances; the cell of its queue updates head and count on the way.
// The entry RAM is then written or read as the token enters r_tok_reg, and
// the response register loads from that stage. Throughput: one request per
// cycle unless rsp is stalled; the chain holds many in flight.
// Stall: while rsp is held and rsp_ready is low the whole chain holds and
// req_ready is low.
// Reset: all queues empty; entries are undefined until written.
// ---------------------------------------------------------------------------
module multi_queue_priority_deque #(
    parameter int NUM_QUEUES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire mqpd_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output mqpd_pkg::rsp_t      rsp
);

    import mqpd_pkg::*;

    localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WIDTH  = TAG_BITS + 1;
    localparam int IDX_N  = 2 ** QIDX_BITS;

    logic                      adv;
    logic [QUEUE_MAX_BITS-1:0] wrap_tab [IDX_N];
    tok_t                      entry_tok;
    logic                      chain_valid [NUM_QUEUES + 1];
    tok_t                      chain_tok   [NUM_QUEUES + 1];

    tok_t                      tail_tok;
    logic                      tail_valid;
    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_addr;
    logic [WIDTH-1:0]          ram_wdata;
    logic [WIDTH-1:0]          ram_rdata;

    logic                      r_valid_reg;
    tok_t                      r_tok_reg;
    logic                      rsp_valid_reg;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;
    logic                      r_taken;

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;

    for (genvar k = 0; k < IDX_N; k++)
    begin : g_wrap
        assign wrap_tab[k] = QUEUE_MAX_BITS'(k % NUM_QUEUES);
    end

    always_comb
    begin
        entry_tok        = '0;
        entry_tok.mode   = req.mode;
        entry_tok.queue  = wrap_tab[req.queue_index];
        entry_tok.tag    = req.item_tag;
        entry_tok.urgent = req.urgent;
        entry_tok.code   = RES_DONE;
    end

    assign chain_valid[0] = req_valid;
    assign chain_tok[0]   = entry_tok;

    for (genvar i = 0; i < NUM_QUEUES; i++)
    begin : g_cell
        mqpd_cell #(
            .CELL_ID     (i),
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .tok_valid_in  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .tok_valid_out (chain_valid[i + 1]),
            .tok_out       (chain_tok[i + 1])
        );
    end

    assign tail_valid = chain_valid[NUM_QUEUES];
    assign tail_tok   = chain_tok[NUM_QUEUES];

    assign ram_we    = adv && tail_valid && (tail_tok.code == RES_DONE)
                       && (tail_tok.mode == MODE_ADD);
    assign ram_re    = adv && tail_valid && (tail_tok.code == RES_DONE)
                       && (tail_tok.mode == MODE_TAKE);
    assign ram_addr  = AW'(tail_tok.queue[QW-1:0]) * AW'(QUEUE_DEPTH)
                       + AW'(tail_tok.slot[HW-1:0]);
    assign ram_wdata = {tail_tok.urgent, TAG_BITS'(tail_tok.tag)};

    mqpd_ram #(
        .WIDTH (WIDTH),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign r_taken = (r_tok_reg.code == RES_DONE) && (r_tok_reg.mode == MODE_TAKE);

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.result_code  = r_tok_reg.code;
        rsp_next.new_length   = LEN_BITS'(r_tok_reg.cnt);
        if (r_taken)
        begin
            rsp_next.taken_tag    = TAG_IN_BITS'(ram_rdata[TAG_BITS-1:0]);
            rsp_next.taken_urgent = ram_rdata[TAG_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg   <= tail_valid;
            rsp_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_tok_reg <= tail_tok;
            rsp_reg   <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- rtl/mqpd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqpd_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module mqpd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                      wdata,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/mqpd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqpd_cell
// One queue's head and count; updates them when a passing token hits it and succeeds.
// ---------------------------------------------------------------------------
module mqpd_cell #(
    parameter int CELL_ID     = 0,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire logic           tok_valid_in,
    input  wire mqpd_pkg::tok_t tok_in,
    output logic                tok_valid_out,
    output mqpd_pkg::tok_t      tok_out
);

    import mqpd_pkg::*;

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = HW + 1;

    logic [HW-1:0] head_reg;
    logic [HW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          valid_reg;
    tok_t          tok_reg;
    tok_t          tok_next;

    logic          hit;
    logic          full;
    logic          empty;
    logic [HW-1:0] head_dec;
    logic [HW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [HW-1:0] tail_slot;

    assign hit      = tok_valid_in && (tok_in.queue == QUEUE_MAX_BITS'(CELL_ID));
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? HW'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == HW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_reg} + SW'(count_reg);
    assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : HW'(tail_sum);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        tok_next   = tok_in;
        if (hit)
        begin
            if (tok_in.mode == MODE_ADD)
            begin
                if (full)
                begin
                    tok_next.code = RES_FULL;
                    tok_next.cnt  = COUNT_MAX_BITS'(count_reg);
                end
                else
                begin
                    if (tok_in.urgent)
                    begin
                        head_next     = head_dec;
                        tok_next.slot = SLOT_MAX_BITS'(head_dec);
                    end
                    else
                    begin
                        tok_next.slot = SLOT_MAX_BITS'(tail_slot);
                    end
                    count_next    = count_reg + 1'b1;
                    tok_next.code = RES_DONE;
                    tok_next.cnt  = COUNT_MAX_BITS'(count_next);
                end
            end
            else
            begin
                if (empty)
                begin
                    tok_next.code = RES_EMPTY;
                    tok_next.cnt  = '0;
                end
                else
                begin
                    head_next     = head_inc;
                    count_next    = count_reg - 1'b1;
                    tok_next.slot = SLOT_MAX_BITS'(head_reg);
                    tok_next.code = RES_DONE;
                    tok_next.cnt  = COUNT_MAX_BITS'(count_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tok_valid_in;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;

endmodule
`default_nettype wire

// ----- rtl/mqpd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mqpd_checker
// Port-level checks of the queue bank, bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_queue_priority_deque_assert.svh"

module mqpd_checker #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_ready,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_ready,
    input  wire mqpd_pkg::rsp_t rsp
);

    import mqpd_pkg::*;

    `MQPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")

    `MQPD_ASSERT_NOW(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "request taken while response stalled")

    `MQPD_ASSERT_NOW(a_fail_no_item, rsp_valid && (rsp.result_code != RES_DONE), (rsp.taken_tag == '0) && !rsp.taken_urgent, "failed access returned an item")

    `MQPD_ASSERT_NOW(a_empty_len, rsp_valid && (rsp.result_code == RES_EMPTY), rsp.new_length == '0, "empty take reported nonzero length")

    `MQPD_ASSERT_NOW(a_full_len, rsp_valid && (rsp.result_code == RES_FULL), rsp.new_length == LEN_BITS'(QUEUE_DEPTH), "full add reported wrong length")

endmodule

bind multi_queue_priority_deque mqpd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
`default_nettype wire
